### sv/rgb_lighting_effect_generator_defines.svh
// Assertion macros for the lighting effect generator.
`ifndef RGB_LIGHTING_EFFECT_GENERATOR_DEFINES_SVH
`define RGB_LIGHTING_EFFECT_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define RLEG_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("rleg: check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define RLEG_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("rleg: check failed");

`endif

### sv/rleg_pkg.sv
package rleg_pkg;

  localparam int PALETTE_DEPTH = 8;
  localparam int PHASE_BITS    = 10;

  localparam int ELAPSED_W    = 32;
  localparam int PERIOD_W     = 16;
  localparam int PSIZE_W      = 4;
  localparam int CHAN_W       = 8;
  localparam int COLOR_W      = 3 * CHAN_W;
  localparam int PAIR_W       = 2 * COLOR_W;
  localparam int PAIR_REGS    = 4;
  localparam int PAIR_SEL_W   = $clog2(PAIR_REGS);
  localparam int REG_ENTRIES  = 2 * PAIR_REGS;
  localparam int BUILTIN_SIZE = 6;
  localparam int MAX_SIZE     = (PALETTE_DEPTH > BUILTIN_SIZE) ? PALETTE_DEPTH : BUILTIN_SIZE;
  localparam int IDX_W        = $clog2(MAX_SIZE);
  localparam int SIZE_W       = IDX_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = PAIR_W;

  // shared divider and multiplier
  localparam int DIV_R_W = PERIOD_W + 1;
  localparam int CNT_W   = $clog2(ELAPSED_W + 1);
  localparam int MUL_W   = 64;
  localparam int OPND_W  = 32;
  localparam int NUM_W   = CHAN_W + PERIOD_W;
  localparam int DVD_W   = NUM_W + 2;

  // phase folding
  localparam int PH_FULL  = 1 << PHASE_BITS;
  localparam int PH_HALF  = PH_FULL / 2;
  localparam int PH_QUART = PH_FULL / 4;
  localparam int PHASE_K_W = PHASE_BITS - 1;

  // cosine in unsigned Q30
  localparam int Q_FRAC  = 30;
  localparam int T_W     = Q_FRAC + 1;
  localparam int THETA_W = Q_FRAC + 1;
  localparam logic [T_W-1:0]    Q_ONE      = T_W'(1) << Q_FRAC;
  localparam logic [OPND_W-1:0] THETA_HALF = 32'd3373259426;  // 2*pi in Q30, halved
  localparam int HORNER_STEPS = 6;
  localparam int H_W = 3;

  // Reciprocals for the Horner divisors d = 2^pre * odd: ceil(2^post / odd).
  localparam logic [OPND_W-1:0] HREC_M0 = 32'(((64'd1 << 38) + 64'd90) / 64'd91);
  localparam logic [OPND_W-1:0] HREC_M1 = 32'(((64'd1 << 37) + 64'd32) / 64'd33);
  localparam logic [OPND_W-1:0] HREC_M2 = 32'(((64'd1 << 37) + 64'd44) / 64'd45);
  localparam logic [OPND_W-1:0] HREC_M3 = 32'(((64'd1 << 34) + 64'd6) / 64'd7);
  localparam logic [OPND_W-1:0] HREC_M4 = 32'(((64'd1 << 35) + 64'd14) / 64'd15);
  localparam logic [OPND_W-1:0] HREC_M5 = 32'(((64'd1 << 33) + 64'd2) / 64'd3);

  typedef struct packed {
    logic [1:0]        pre;
    logic [5:0]        post;
    logic [OPND_W-1:0] mult;
  } hrec_t;

  typedef enum logic [1:0] {
    MODE_BREATH   = 2'd0,
    MODE_CYCLE    = 2'd1,
    MODE_COLORFUL = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_PERIOD = 3'd1,
    CFG_PSIZE  = 3'd2,
    CFG_SOLID  = 3'd3,
    CFG_PAIR0  = 3'd4,
    CFG_PAIR1  = 3'd5,
    CFG_PAIR2  = 3'd6,
    CFG_PAIR3  = 3'd7
  } cfg_idx_e;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;
  localparam logic [COLOR_W-1:0]  SOLID_RST  = 24'hFFFFFF;
  localparam logic [PAIR_W-1:0]   PAIR0_RST  = 48'h0000FF_FF0000;
  localparam logic [PAIR_W-1:0]   PAIR1_RST  = 48'hFFFF00_00FF00;
  localparam logic [PAIR_W-1:0]   PAIR2_RST  = 48'hFF00FF_00FFFF;
  localparam logic [PAIR_W-1:0]   PAIR3_RST  = 48'h000000_000000;

  function automatic logic [COLOR_W-1:0] builtin_color(input logic [IDX_W-1:0] idx);
    logic [COLOR_W-1:0] c;
    case (idx)
      IDX_W'(0): c = 24'hFF0000;
      IDX_W'(1): c = 24'h0000FF;
      IDX_W'(2): c = 24'h00FF00;
      IDX_W'(3): c = 24'hFFFF00;
      IDX_W'(4): c = 24'h00FFFF;
      IDX_W'(5): c = 24'hFF00FF;
      default:   c = '0;
    endcase
    return c;
  endfunction

  function automatic hrec_t horner_recip(input logic [H_W-1:0] h);
    hrec_t r;
    case (h)
      3'd0:    r = '{pre: 2'd1, post: 6'd38, mult: HREC_M0};  // 182
      3'd1:    r = '{pre: 2'd2, post: 6'd37, mult: HREC_M1};  // 132
      3'd2:    r = '{pre: 2'd1, post: 6'd37, mult: HREC_M2};  // 90
      3'd3:    r = '{pre: 2'd3, post: 6'd34, mult: HREC_M3};  // 56
      3'd4:    r = '{pre: 2'd1, post: 6'd35, mult: HREC_M4};  // 30
      default: r = '{pre: 2'd2, post: 6'd33, mult: HREC_M5};  // 12
    endcase
    return r;
  endfunction

endpackage

### sv/rgb_lighting_effect_generator.sv
// Channel   Dir  Handshake              Payload
// cfg       in   cfg_we_i (no wait)     cfg_index_i, cfg_data_i
// frame     in   in_valid_i/in_ready_o  elapsed_ms_i, restart_i
// result    out  out_valid_o/out_ready_i red_o, green_o, blue_o, brightness_o, flags
//
// A frame keeps the block busy until its result is written, in every mode;
// in_ready_o is high again in the cycle after, so frames never overlap:
// a bit-serial divide for step and remainder, two palette picks, then either
// three mix channels (two multiplies, a load and a divide each)
// or a phase divide and the Horner cosine on the shared 32x32 multiplier.
// Reset clears state, flags memory and the output register; config takes its defaults.
// A result waits in the output register; a stall there holds the next result
// in the final state until the register frees.
module rgb_lighting_effect_generator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rleg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rleg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rleg_pkg::ELAPSED_W-1:0]     elapsed_ms_i,
  input  logic                               restart_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rleg_pkg::CHAN_W-1:0]        red_o,
  output logic [rleg_pkg::CHAN_W-1:0]        green_o,
  output logic [rleg_pkg::CHAN_W-1:0]        blue_o,
  output logic [rleg_pkg::CHAN_W-1:0]        brightness_o,
  output logic                               color_changed_o,
  output logic                               brightness_changed_o
);
  import rleg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_MAIN, S_PICKA, S_PICKB, S_PHASE, S_THETA, S_X2, S_X2REG,
    S_HMUL, S_HREC, S_HSUB, S_FINMUL, S_LEVEL, S_MIXA, S_MIXB, S_MIXL,
    S_MIXDIV, S_WRITE
  } state_e;

  // configuration
  logic [1:0]          mode_q;
  logic [PERIOD_W-1:0] period_q;
  logic [PSIZE_W-1:0]  psize_field_q;
  logic [COLOR_W-1:0]  solid_q;
  logic [PAIR_W-1:0]   pal_q [PAIR_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_BREATH;
      period_q      <= PERIOD_RST;
      psize_field_q <= '0;
      solid_q       <= SOLID_RST;
      pal_q[0]      <= PAIR0_RST;
      pal_q[1]      <= PAIR1_RST;
      pal_q[2]      <= PAIR2_RST;
      pal_q[3]      <= PAIR3_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE:   mode_q        <= cfg_data_i[1:0];
        CFG_PERIOD: period_q      <= cfg_data_i[PERIOD_W-1:0];
        CFG_PSIZE:  psize_field_q <= cfg_data_i[PSIZE_W-1:0];
        CFG_SOLID:  solid_q       <= cfg_data_i[COLOR_W-1:0];
        CFG_PAIR0:  pal_q[0]      <= cfg_data_i;
        CFG_PAIR1:  pal_q[1]      <= cfg_data_i;
        CFG_PAIR2:  pal_q[2]      <= cfg_data_i;
        CFG_PAIR3:  pal_q[3]      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // datapath registers
  state_e               state_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIV_R_W-1:0]   div_r_q;
  logic [ELAPSED_W-1:0] div_x_q;
  logic [DIV_R_W-1:0]   div_d_q;
  logic [IDX_W-1:0]     mod_q;
  logic [PERIOD_W-1:0]  rem_q;
  logic                 restart_q;
  logic [COLOR_W-1:0]   col_a_q;
  logic [COLOR_W-1:0]   col_b_q;
  logic [MUL_W-1:0]     mul_q;
  logic [PHASE_K_W-1:0] k_q;
  logic                 neg_q;
  logic [OPND_W-1:0]    x2_q;
  logic [T_W-1:0]       t_q;
  logic [H_W-1:0]       h_q;
  logic [1:0]           ch_q;
  logic [NUM_W-1:0]     acc_q;
  logic [COLOR_W-1:0]   color_q;
  logic [CHAN_W-1:0]    level_q;
  logic                 shown_q;
  logic [COLOR_W-1:0]   last_color_q;
  logic [CHAN_W-1:0]    last_level_q;
  logic                 out_valid_q;
  logic [COLOR_W-1:0]   out_color_q;
  logic [CHAN_W-1:0]    out_level_q;
  logic                 out_cc_q;
  logic                 out_bc_q;

  // derived configuration
  logic [PERIOD_W-1:0] per_eff;
  logic [SIZE_W-1:0]   psize;
  logic                builtin;

  always_comb begin
    per_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;
    builtin = (psize_field_q == '0);
    if (builtin) begin
      psize = SIZE_W'(BUILTIN_SIZE);
    end else if (int'(psize_field_q) > PALETTE_DEPTH) begin
      psize = SIZE_W'(PALETTE_DEPTH);
    end else begin
      psize = SIZE_W'(psize_field_q);
    end
  end

  // restoring divider step, one quotient bit per cycle
  logic [DIV_R_W:0]     div_shift;
  logic [DIV_R_W+1:0]   div_trial;
  logic                 div_bit;
  logic [DIV_R_W-1:0]   div_r_d;
  logic [ELAPSED_W-1:0] div_x_d;
  logic                 cnt_last;

  always_comb begin
    div_shift = {div_r_q, div_x_q[ELAPSED_W-1]};
    div_trial = {1'b0, div_shift} - {2'b00, div_d_q};
    div_bit   = ~div_trial[DIV_R_W+1];
    div_r_d   = div_bit ? div_trial[DIV_R_W-1:0] : div_shift[DIV_R_W-1:0];
    div_x_d   = {div_x_q[ELAPSED_W-2:0], div_bit};
    cnt_last  = (cnt_q == CNT_W'(1));
  end

  // step mod palette size, fed by the quotient bits MSB first
  logic [SIZE_W-1:0] mod_acc;
  logic [IDX_W-1:0]  mod_d;
  logic [SIZE_W-1:0] mod_inc;
  logic [IDX_W-1:0]  idx_next;

  always_comb begin
    mod_acc  = {mod_q, div_bit};
    mod_d    = (mod_acc >= psize) ? IDX_W'(mod_acc - psize) : mod_acc[IDX_W-1:0];
    mod_inc  = {1'b0, mod_q} + SIZE_W'(1);
    idx_next = (mod_inc == psize) ? '0 : mod_inc[IDX_W-1:0];
  end

  // palette lookup, single read port
  logic [IDX_W-1:0]      pick_idx;
  logic [PAIR_SEL_W-1:0] pair_sel;
  logic [COLOR_W-1:0]    pick_color;

  always_comb begin
    pick_idx = (state_q == S_PICKB) ? idx_next : mod_q;
    pair_sel = PAIR_SEL_W'(pick_idx >> 1);
    if (builtin) begin
      pick_color = builtin_color(pick_idx);
    end else if (int'(pick_idx) < REG_ENTRIES) begin
      pick_color = pick_idx[0] ? pal_q[pair_sel][PAIR_W-1:COLOR_W]
                               : pal_q[pair_sel][COLOR_W-1:0];
    end else begin
      pick_color = '0;
    end
  end

  // phase fold to the first quarter wave
  logic [PHASE_BITS:0]   ph_p;
  logic [PHASE_BITS:0]   ph_j;
  logic [PHASE_BITS:0]   ph_k;
  logic                  ph_neg;

  always_comb begin
    ph_p   = {1'b0, div_x_d[PHASE_BITS-1:0]};
    ph_j   = (int'(ph_p) > PH_HALF) ? (PHASE_BITS+1)'(PH_FULL) - ph_p : ph_p;
    ph_neg = (int'(ph_j) > PH_QUART);
    ph_k   = ph_neg ? (PHASE_BITS+1)'(PH_HALF) - ph_j : ph_j;
  end

  // shared multiplier operands
  hrec_t              hrec;
  logic [OPND_W-1:0]  mul_u;
  logic [THETA_W-1:0] theta;
  logic [1:0]         byte_sel;
  logic [CHAN_W-1:0]  chan_a;
  logic [CHAN_W-1:0]  chan_b;
  logic [OPND_W-1:0]  mul_a;
  logic [OPND_W-1:0]  mul_b;

  always_comb begin
    hrec     = horner_recip(h_q);
    mul_u    = mul_q[Q_FRAC+OPND_W-1:Q_FRAC];
    theta    = THETA_W'(mul_q >> (PHASE_BITS - 1));
    byte_sel = 2'd2 - ch_q;
    chan_a   = col_a_q[byte_sel*CHAN_W +: CHAN_W];
    chan_b   = col_b_q[byte_sel*CHAN_W +: CHAN_W];
    case (state_q)
      S_THETA: begin
        mul_a = THETA_HALF;
        mul_b = OPND_W'(k_q);
      end
      S_X2: begin
        mul_a = OPND_W'(theta);
        mul_b = OPND_W'(theta);
      end
      S_HMUL, S_FINMUL: begin
        mul_a = x2_q;
        mul_b = OPND_W'(t_q);
      end
      S_HREC: begin
        mul_a = mul_u >> hrec.pre;
        mul_b = hrec.mult;
      end
      S_MIXA: begin
        mul_a = OPND_W'(chan_a);
        mul_b = OPND_W'(per_eff - rem_q);
      end
      S_MIXB: begin
        mul_a = OPND_W'(chan_b);
        mul_b = OPND_W'(rem_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Horner update, level and mix numerator
  logic [T_W-1:0]     h_quot;
  logic [OPND_W-1:0]  lv_v;
  logic [39:0]        lv_sum;
  logic [NUM_W:0]     mix_num;
  logic [DVD_W-1:0]   mix_dvd;
  logic               flag_cc;
  logic               flag_bc;

  always_comb begin
    h_quot  = T_W'(mul_q >> hrec.post);
    // folded upper half mirrors the level around one half
    lv_v    = neg_q ? (OPND_W'(1) << (OPND_W - 1)) - OPND_W'(mul_u[OPND_W-1:1])
                    : OPND_W'(mul_u[OPND_W-1:1]);
    lv_sum  = (40'(lv_v) << CHAN_W) - 40'(lv_v) + (40'd1 << Q_FRAC);
    mix_num = (NUM_W+1)'(acc_q) + (NUM_W+1)'(mul_q[NUM_W-1:0]);
    mix_dvd = {mix_num[NUM_W-1:0], 1'b0} + DVD_W'(per_eff);
    flag_cc = restart_q || !shown_q || (color_q != last_color_q);
    flag_bc = restart_q || !shown_q || (level_q != last_level_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      div_r_q      <= '0;
      div_x_q      <= '0;
      div_d_q      <= '0;
      mod_q        <= '0;
      rem_q        <= '0;
      restart_q    <= 1'b0;
      col_a_q      <= '0;
      col_b_q      <= '0;
      mul_q        <= '0;
      k_q          <= '0;
      neg_q        <= 1'b0;
      x2_q         <= '0;
      t_q          <= Q_ONE;
      h_q          <= '0;
      ch_q         <= '0;
      acc_q        <= '0;
      color_q      <= '0;
      level_q      <= '0;
      shown_q      <= 1'b0;
      last_color_q <= '0;
      last_level_q <= '0;
      out_valid_q  <= 1'b0;
      out_color_q  <= '0;
      out_level_q  <= '0;
      out_cc_q     <= 1'b0;
      out_bc_q     <= 1'b0;
    end else begin
      mul_q <= mul_a * mul_b;
      // S_WRITE reloads the output register itself
      if (out_valid_q && out_ready_i && (state_q != S_WRITE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            div_r_q   <= '0;
            div_x_q   <= elapsed_ms_i;
            div_d_q   <= DIV_R_W'(per_eff);
            cnt_q     <= CNT_W'(ELAPSED_W);
            mod_q     <= '0;
            restart_q <= restart_i;
            ch_q      <= '0;
            state_q   <= S_MAIN;
          end
        end
        S_MAIN: begin
          div_r_q <= div_r_d;
          div_x_q <= div_x_d;
          mod_q   <= mod_d;
          cnt_q   <= cnt_q - CNT_W'(1);
          if (cnt_last) begin
            rem_q   <= div_r_d[PERIOD_W-1:0];
            state_q <= S_PICKA;
          end
        end
        S_PICKA: begin
          col_a_q <= pick_color;
          state_q <= S_PICKB;
        end
        S_PICKB: begin
          col_b_q <= pick_color;
          if (mode_q == MODE_CYCLE) begin
            state_q <= S_MIXA;
          end else begin
            div_r_q <= DIV_R_W'(rem_q);
            div_x_q <= '0;
            cnt_q   <= CNT_W'(PHASE_BITS);
            state_q <= S_PHASE;
          end
        end
        S_PHASE: begin
          div_r_q <= div_r_d;
          div_x_q <= div_x_d;
          cnt_q   <= cnt_q - CNT_W'(1);
          if (cnt_last) begin
            k_q     <= PHASE_K_W'(ph_k);
            neg_q   <= ph_neg;
            state_q <= S_THETA;
          end
        end
        S_THETA: state_q <= S_X2;
        S_X2:    state_q <= S_X2REG;
        S_X2REG: begin
          x2_q    <= mul_u;
          t_q     <= Q_ONE;
          h_q     <= '0;
          state_q <= S_HMUL;
        end
        S_HMUL: state_q <= S_HREC;
        S_HREC: state_q <= S_HSUB;
        S_HSUB: begin
          t_q <= Q_ONE - h_quot;
          if (h_q == H_W'(HORNER_STEPS - 1)) begin
            state_q <= S_FINMUL;
          end else begin
            h_q     <= h_q + H_W'(1);
            state_q <= S_HMUL;
          end
        end
        S_FINMUL: state_q <= S_LEVEL;
        S_LEVEL: begin
          level_q <= lv_sum[Q_FRAC+CHAN_W:Q_FRAC+1];
          color_q <= (mode_q == MODE_COLORFUL) ? col_a_q : solid_q;
          state_q <= S_WRITE;
        end
        S_MIXA: state_q <= S_MIXB;
        S_MIXB: begin
          acc_q   <= mul_q[NUM_W-1:0];
          state_q <= S_MIXL;
        end
        S_MIXL: begin
          // quotient fits eight bits, so start with the top of the dividend
          div_r_q <= DIV_R_W'(mix_dvd >> CHAN_W);
          div_x_q <= {mix_dvd[CHAN_W-1:0], (ELAPSED_W - CHAN_W)'(0)};
          div_d_q <= {per_eff, 1'b0};
          cnt_q   <= CNT_W'(CHAN_W);
          state_q <= S_MIXDIV;
        end
        S_MIXDIV: begin
          div_r_q <= div_r_d;
          div_x_q <= div_x_d;
          cnt_q   <= cnt_q - CNT_W'(1);
          if (cnt_last) begin
            color_q[byte_sel*CHAN_W +: CHAN_W] <= div_x_d[CHAN_W-1:0];
            if (ch_q == 2'd2) begin
              level_q <= '1;
              state_q <= S_WRITE;
            end else begin
              ch_q    <= ch_q + 2'd1;
              state_q <= S_MIXA;
            end
          end
        end
        S_WRITE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_color_q  <= color_q;
            out_level_q  <= level_q;
            out_cc_q     <= flag_cc;
            out_bc_q     <= flag_bc;
            shown_q      <= 1'b1;
            last_color_q <= color_q;
            last_level_q <= level_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o           = (state_q == S_IDLE);
  assign out_valid_o          = out_valid_q;
  assign red_o                = out_color_q[3*CHAN_W-1:2*CHAN_W];
  assign green_o              = out_color_q[2*CHAN_W-1:CHAN_W];
  assign blue_o               = out_color_q[CHAN_W-1:0];
  assign brightness_o         = out_level_q;
  assign color_changed_o      = out_cc_q;
  assign brightness_changed_o = out_bc_q;

  logic div_active;
  assign div_active = (state_q == S_MAIN) || (state_q == S_PHASE) || (state_q == S_MIXDIV);

`include "rgb_lighting_effect_generator_defines.svh"

  `RLEG_ASSERT_NEXT(a_busy_after_transfer, in_valid_i && in_ready_o, !in_ready_o)
  `RLEG_ASSERT_NOW(a_div_rem_below_divisor, div_active, div_r_q < div_d_q)
  `RLEG_ASSERT_NOW(a_mod_below_size, state_q == S_MAIN, SIZE_W'(mod_q) < psize)
  `RLEG_ASSERT_NOW(a_horner_t_range, state_q == S_HMUL, (t_q <= Q_ONE) && (t_q >= (Q_ONE >> 1)))

endmodule

### tb/sv/rleg_frame_checker.sv
`timescale 1ns / 100ps

module rleg_frame_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rleg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rleg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [rleg_pkg::ELAPSED_W-1:0]  elapsed_ms_i,
  input  logic                            restart_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [rleg_pkg::CHAN_W-1:0]     red_i,
  input  logic [rleg_pkg::CHAN_W-1:0]     green_i,
  input  logic [rleg_pkg::CHAN_W-1:0]     blue_i,
  input  logic [rleg_pkg::CHAN_W-1:0]     brightness_i,
  input  logic                            color_changed_i,
  input  logic                            brightness_changed_i,
  output int                              error_count_o,
  output int                              pending_o
);
  import rleg_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] level;
    logic              color_chg;
    logic              level_chg;
  } frame_color_t;

  localparam logic [63:0] Q1       = 64'd1 << Q_FRAC;
  localparam logic [63:0] TWO_PI_Q = 64'd6746518852;
  // Horner divisors, first one in the low byte
  localparam logic [47:0] HORNER_DIVS = {8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};
  // default palette, entry 0 in the low bits
  localparam logic [143:0] DEFAULT_COLORS = {24'hFF00FF, 24'h00FFFF, 24'hFFFF00,
                                             24'h00FF00, 24'h0000FF, 24'hFF0000};

  logic [1:0]          mode_q;
  logic [PERIOD_W-1:0] period_q;
  logic [PSIZE_W-1:0]  psize_q;
  logic [COLOR_W-1:0]  solid_q;
  logic [PAIR_W-1:0]   pair_q [0:PAIR_REGS-1];
  logic                shown_q;
  logic [COLOR_W-1:0]  last_color_q;
  logic [CHAN_W-1:0]   last_level_q;

  frame_color_t expected_frames [$];
  int errors = 0;

  assign error_count_o = errors;

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= 10) $display("%0t ns frame check: %s", $time, msg);
  endtask

  function automatic logic [CHAN_W-1:0] breath_level(input logic [63:0] rem,
                                                     input logic [63:0] per);
    logic [63:0] p, j, k, theta, x2, t;
    longint c, v;
    logic neg;
    int d;
    p = (rem << PHASE_BITS) / per;
    j = (p > PH_HALF) ? PH_FULL - p : p;
    k = j;
    neg = 1'b0;
    // fold the angle into the first quadrant
    if (j > PH_QUART) begin
      k = PH_HALF - j;
      neg = 1'b1;
    end
    theta = (TWO_PI_Q * k) >> PHASE_BITS;
    x2 = (theta * theta) >> Q_FRAC;
    t = Q1;
    for (d = 0; d < HORNER_STEPS; d++) begin
      t = Q1 - ((x2 * t) >> Q_FRAC) / HORNER_DIVS[8*d +: 8];
    end
    c = longint'(Q1) - longint'(((x2 * t) >> Q_FRAC) >> 1);
    if (neg) c = -c;
    v = longint'(Q1) - c;
    if (v < 0) v = 0;
    if (v > longint'(2 * Q1)) v = longint'(2 * Q1);
    return CHAN_W'((64'd255 * 64'(v) + Q1) >> 31);
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color(input logic [63:0] n);
    logic [63:0] size, idx;
    logic [PAIR_W-1:0] pair;
    size = (psize_q > PALETTE_DEPTH) ? PALETTE_DEPTH : psize_q;
    if (size == 0) return DEFAULT_COLORS[(n % 6) * 24 +: 24];
    idx = n % size;
    if (idx >= REG_ENTRIES) return '0;
    pair = pair_q[idx[2:1]];
    return idx[0] ? pair[47:24] : pair[23:0];
  endfunction

  function automatic logic [CHAN_W-1:0] mix_channel(input logic [63:0] a, input logic [63:0] b,
                                                    input logic [63:0] rem,
                                                    input logic [63:0] per);
    logic [63:0] num;
    num = a * (per - rem) + b * rem;
    return CHAN_W'((2 * num + per) / (2 * per));
  endfunction

  // updates the shown-frame memory as a side effect
  function automatic frame_color_t predict_frame(input logic [ELAPSED_W-1:0] ms,
                                                 input logic restart);
    logic [63:0] per, step, rem;
    logic [COLOR_W-1:0] ca, cb, color;
    logic [CHAN_W-1:0] level;
    frame_color_t r;
    per = (period_q == 0) ? 64'd1 : 64'(period_q);
    step = 64'(ms) / per;
    rem = 64'(ms) % per;
    if (restart) shown_q = 1'b0;
    if (mode_q == MODE_CYCLE) begin
      ca = pick_color(step);
      cb = pick_color(step + 1);
      color = {mix_channel(ca[23:16], cb[23:16], rem, per),
               mix_channel(ca[15:8], cb[15:8], rem, per),
               mix_channel(ca[7:0], cb[7:0], rem, per)};
      level = 8'hFF;
    end else begin
      // mode 3 falls back to plain breathing
      color = (mode_q == MODE_COLORFUL) ? pick_color(step) : solid_q;
      level = breath_level(rem, per);
    end
    r.red = color[23:16];
    r.green = color[15:8];
    r.blue = color[7:0];
    r.level = level;
    r.color_chg = !shown_q || (color != last_color_q);
    r.level_chg = !shown_q || (level != last_level_q);
    shown_q = 1'b1;
    last_color_q = color;
    last_level_q = level;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    frame_color_t got, want;
    if (!rst_ni) begin
      mode_q = MODE_BREATH;
      period_q = PERIOD_RST;
      psize_q = '0;
      solid_q = SOLID_RST;
      pair_q[0] = PAIR0_RST;
      pair_q[1] = PAIR1_RST;
      pair_q[2] = PAIR2_RST;
      pair_q[3] = PAIR3_RST;
      shown_q = 1'b0;
      last_color_q = '0;
      last_level_q = '0;
      expected_frames.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.red = red_i;
        got.green = green_i;
        got.blue = blue_i;
        got.level = brightness_i;
        got.color_chg = color_changed_i;
        got.level_chg = brightness_changed_i;
        if (expected_frames.size() == 0) begin
          note_failure($sformatf("result with no frame pending: rgb %06h lvl %0d",
                                 {got.red, got.green, got.blue}, got.level));
        end else begin
          want = expected_frames.pop_front();
          if (got !== want) begin
            note_failure($sformatf(
              "exp rgb %06h lvl %0d cc %0b bc %0b, got rgb %06h lvl %0d cc %0b bc %0b",
              {want.red, want.green, want.blue}, want.level, want.color_chg,
              want.level_chg, {got.red, got.green, got.blue}, got.level,
              got.color_chg, got.level_chg));
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MODE:   mode_q = cfg_data_i[1:0];
          CFG_PERIOD: period_q = cfg_data_i[PERIOD_W-1:0];
          CFG_PSIZE:  psize_q = cfg_data_i[PSIZE_W-1:0];
          CFG_SOLID:  solid_q = cfg_data_i[COLOR_W-1:0];
          CFG_PAIR0:  pair_q[0] = cfg_data_i;
          CFG_PAIR1:  pair_q[1] = cfg_data_i;
          CFG_PAIR2:  pair_q[2] = cfg_data_i;
          default:    pair_q[3] = cfg_data_i;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_frames.push_back(predict_frame(elapsed_ms_i, restart_i));
      end
      pending_o <= expected_frames.size();
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import rleg_pkg::*;

  localparam int          CYCLE_LIMIT     = 1000000;
  localparam int          PHASES          = 8;
  localparam int          ITEMS_PER_PHASE = 50;
  localparam int          LONG_HOLD       = 600;
  localparam int          TAIL_CYCLES     = 80;
  localparam logic [1:0]  MODE_UNUSED     = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [ELAPSED_W-1:0]  elapsed_ms_i;
  logic                  restart_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [CHAN_W-1:0]     red_o;
  logic [CHAN_W-1:0]     green_o;
  logic [CHAN_W-1:0]     blue_o;
  logic [CHAN_W-1:0]     brightness_o;
  logic                  color_changed_o;
  logic                  brightness_changed_o;

  int   error_count;
  int   pending;
  int   hold_ticket = 0;
  logic quiet_rx = 1'b0;
  logic quiet_tx = 1'b0;
  int   cycle_count;

  always #6 clk_i = ~clk_i;

  rgb_lighting_effect_generator dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .elapsed_ms_i         (elapsed_ms_i),
    .restart_i            (restart_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .red_o                (red_o),
    .green_o              (green_o),
    .blue_o               (blue_o),
    .brightness_o         (brightness_o),
    .color_changed_o      (color_changed_o),
    .brightness_changed_o (brightness_changed_o)
  );

  rleg_frame_checker frame_check (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_i           (in_ready_o),
    .elapsed_ms_i         (elapsed_ms_i),
    .restart_i            (restart_i),
    .out_valid_i          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .red_i                (red_o),
    .green_i              (green_o),
    .blue_i               (blue_o),
    .brightness_i         (brightness_o),
    .color_changed_i      (color_changed_o),
    .brightness_changed_i (brightness_changed_o),
    .error_count_o        (error_count),
    .pending_o            (pending)
  );

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 0;
    if (roll < 94) return $urandom_range(1, 4);
    return $urandom_range(15, 80);
  endfunction

  task automatic send_frame(input logic [ELAPSED_W-1:0] ms, input logic rs);
    int gap;
    gap = quiet_tx ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    elapsed_ms_i <= ms;
    restart_i <= rs;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop offering frames and wait for every pending result
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // leaves the write enable high; caller lowers it after the last write
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  initial begin : receiver
    int stall_left;
    int served;
    stall_left = 0;
    served = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_ticket != served) begin
        served = hold_ticket;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet_rx) stall_left = idle_gap();
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int p, i, roll, eff;
    logic [PERIOD_W-1:0] per;
    logic [ELAPSED_W-1:0] t_ms;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_MODE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    elapsed_ms_i = '0;
    restart_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: breathing white over 1000 ms
    send_frame(32'd0, 1'b0);
    send_frame(32'd0, 1'b0);
    send_frame(32'd250, 1'b0);
    send_frame(32'd500, 1'b0);
    send_frame(32'd750, 1'b0);
    send_frame(32'd999, 1'b0);
    send_frame(32'd1000, 1'b1);
    send_frame(32'hFFFFFFFF, 1'b0);
    settle();
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_CYCLE));
    cfg_we_i <= 1'b0;
    send_frame(32'd0, 1'b0);
    send_frame(32'd500, 1'b0);
    send_frame(32'd5999, 1'b0);
    send_frame(32'd6000, 1'b0);
    send_frame(32'hFFFFFFFF, 1'b0);
    settle();
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_COLORFUL));
    cfg_we_i <= 1'b0;
    send_frame(32'd1500, 1'b0);
    send_frame(32'd5250, 1'b0);
    settle();
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_UNUSED));
    cfg_we_i <= 1'b0;
    send_frame(32'd400, 1'b0);
    // zero period with an oversized palette size
    settle();
    write_reg(CFG_PERIOD, '0);
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_CYCLE));
    write_reg(CFG_PSIZE, CFG_DATA_W'(15));
    cfg_we_i <= 1'b0;
    send_frame(32'd7, 1'b0);
    send_frame(32'd8, 1'b0);
    settle();
    write_reg(CFG_PERIOD, CFG_DATA_W'(16'hFFFF));
    write_reg(CFG_PSIZE, CFG_DATA_W'(8));
    write_reg(CFG_PAIR0, {CFG_DATA_W{1'b1}});
    write_reg(CFG_PAIR3, 48'hFFFFFF_000000);
    write_reg(CFG_SOLID, '0);
    cfg_we_i <= 1'b0;
    send_frame(32'd7 * 32'd65535 + 32'd32767, 1'b0);
    send_frame(32'hFFFFFFFF, 1'b1);

    for (p = 0; p < PHASES; p++) begin
      settle();
      quiet_tx = (p == 2) || (p == 5);
      quiet_rx <= (p == 5);
      case (p)
        1:       per = '0;
        3:       per = 16'hFFFF;
        6:       per = 16'd1;
        default: per = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2, 60));
      endcase
      eff = (per == 0) ? 1 : int'(per);
      write_reg(CFG_MODE, CFG_DATA_W'(p % 4));
      write_reg(CFG_PERIOD, CFG_DATA_W'(per));
      case (p)
        0:       write_reg(CFG_PSIZE, '0);
        3:       write_reg(CFG_PSIZE, CFG_DATA_W'(15));
        4:       write_reg(CFG_PSIZE, CFG_DATA_W'(8));
        default: write_reg(CFG_PSIZE, CFG_DATA_W'($urandom_range(0, 15)));
      endcase
      case (p)
        0:       write_reg(CFG_SOLID, '0);
        7:       write_reg(CFG_SOLID, CFG_DATA_W'(24'hFFFFFF));
        default: write_reg(CFG_SOLID, CFG_DATA_W'($urandom & 32'h00FFFFFF));
      endcase
      for (i = 0; i < PAIR_REGS; i++) begin
        if (p == 7) write_reg(cfg_idx_e'(CFG_PAIR0 + i), {CFG_DATA_W{1'b1}});
        else if (p == 1) write_reg(cfg_idx_e'(CFG_PAIR0 + i), '0);
        else write_reg(cfg_idx_e'(CFG_PAIR0 + i), 48'({$urandom, $urandom}));
      end
      cfg_we_i <= 1'b0;
      // output stalls long enough for the block to back up its input
      if (p == 2) hold_ticket <= hold_ticket + 1;

      t_ms = (p % 2) ? $urandom : '0;
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        roll = $urandom_range(99);
        if (roll < 60) t_ms = t_ms + $urandom_range(1, 40);
        else if (roll < 75) t_ms = t_ms + $urandom_range(0, 2 * eff);
        else if (roll < 85) t_ms = $urandom;
        else if (roll < 92) t_ms = 32'hFFFFFFFF - $urandom_range(0, 2000);
        // otherwise the same frame time repeats
        send_frame(t_ms, $urandom_range(99) < 6);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
